[sv/rwct_pkg.sv]
`timescale 1ns / 1ps

package rwct_pkg;

    // texture geometry
    localparam int TEX_MAX_WIDTH  = 64;
    localparam int TEX_MAX_HEIGHT = 64;
    localparam int TEX_AREA       = TEX_MAX_WIDTH * TEX_MAX_HEIGHT;
    localparam int NUM_FACES      = 4;
    localparam int STORE_DEPTH    = NUM_FACES * TEX_AREA;
    localparam int ADDR_W         = $clog2(STORE_DEPTH);

    // field widths
    localparam int COLOR_W   = 32;
    localparam int ROW_W     = 10;
    localparam int FRAC_W    = 16;
    localparam int SLICE_H_W = 16;
    localparam int WIDX_W    = 12;
    localparam int TEXSZ_W   = 7;
    localparam int CFG_IDX_W = 2;

    // derived datapath widths
    localparam int PRODX_W   = FRAC_W + TEXSZ_W;
    localparam int NUM_W     = ROW_W + TEXSZ_W;
    localparam int DIV_STEPS = TEXSZ_W;
    localparam int CMP_W     = SLICE_H_W + DIV_STEPS;

    localparam logic [TEXSZ_W-1:0] TEXSZ_RESET = TEXSZ_W'(64);

    typedef enum logic [1:0] {
        REGION_CEILING = 2'd0,
        REGION_WALL    = 2'd1,
        REGION_FLOOR   = 2'd2,
        REGION_TEXEL   = 2'd3
    } region_t;

    typedef enum logic [1:0] {
        FACE_NORTH = 2'd0,
        FACE_SOUTH = 2'd1,
        FACE_WEST  = 2'd2,
        FACE_EAST  = 2'd3
    } face_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CEILING_RGB = 2'd0,
        CFG_FLOOR_RGB   = 2'd1,
        CFG_TEX_WIDTH   = 2'd2,
        CFG_TEX_HEIGHT  = 2'd3
    } cfg_idx_t;

endpackage

[sv/rwct_ram.sv]
`timescale 1ns / 1ps

module rwct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[sv/raycast_wall_column_texturer_core.sv]
`timescale 1ns / 1ps
// Raycaster wall column texturer: one beat in, one beat out, in order.
// Registers in order: classify, products, mirror and divider setup, seven divider
// stages, bounds, store read, output reg. Throughput: one beat per cycle while the skid
// slot is empty; at most one texture store access per cycle, in item order.
// After an output stall the input is ready again the cycle after the skid beat moves out.
// Reset (aresetn low, synchronous): pipeline emptied, config regs reset, store not cleared.

module raycast_wall_column_texturer_core (
    input  logic                            aclk,
    input  logic                            aresetn,

    // config write port
    input  logic                            cfg_wr_en,
    input  logic [rwct_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rwct_pkg::COLOR_W-1:0]    cfg_wdata,

    // input channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_mode,
    input  logic [1:0]                      s_write_texture,
    input  logic [rwct_pkg::WIDX_W-1:0]     s_write_index,
    input  logic [rwct_pkg::COLOR_W-1:0]    s_write_value,
    input  logic                            s_hit_side,
    input  logic                            s_dir_x_positive,
    input  logic signed [1:0]               s_dir_y_sign,
    input  logic [rwct_pkg::FRAC_W-1:0]     s_wall_fraction,
    input  logic [rwct_pkg::ROW_W-1:0]      s_row,
    input  logic [rwct_pkg::ROW_W-1:0]      s_slice_start,
    input  logic [rwct_pkg::ROW_W-1:0]      s_slice_end,
    input  logic [rwct_pkg::SLICE_H_W-1:0]  s_slice_height,

    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [rwct_pkg::COLOR_W-1:0]    m_pixel_color,
    output logic [1:0]                      m_region,
    output logic                            m_texel_outside
);

    import rwct_pkg::*;

    // ---------------------------------------------------------------
    // Per-beat control that rides the pipeline through stage e
    // ---------------------------------------------------------------
    typedef struct packed {
        logic               vld;
        region_t            region;
        face_t              face;     // write_texture on texel writes
        logic               mirror;
        logic [WIDX_W-1:0]  windex;
        logic [COLOR_W-1:0] wdata;
    } ctl_t;

    typedef struct packed {
        ctl_t                 ctl;
        logic [ROW_W-1:0]     diff;   // row - slice_start
        logic [FRAC_W-1:0]    frac;
        logic [SLICE_H_W-1:0] height;
    } stg_a_t;

    typedef struct packed {
        ctl_t                 ctl;
        logic [TEXSZ_W-1:0]   tx_raw;
        logic [NUM_W-1:0]     num;    // (row - start) * texture_height
        logic [SLICE_H_W-1:0] height;
    } stg_b_t;

    typedef struct packed {
        ctl_t                 ctl;
        logic [TEXSZ_W-1:0]   tx;
        logic                 tx_out;
        logic [NUM_W-1:0]     rem;
        logic [DIV_STEPS-1:0] q;
        logic                 ovf;    // quotient would not fit (covers height 0)
        logic [SLICE_H_W-1:0] height;
    } stg_div_t;

    typedef struct packed {
        ctl_t                 ctl;
        logic [TEXSZ_W-1:0]   tx;
        logic [DIV_STEPS-1:0] q;
        logic                 outside;
    } stg_e_t;

    typedef struct packed {
        logic    vld;
        region_t region;
        logic    outside;
    } stg_f_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        region_t            region;
        logic               outside;
    } res_t;

    // ---------------------------------------------------------------
    // Config registers
    // ---------------------------------------------------------------
    logic [COLOR_W-1:0] ceiling_rgb_reg;
    logic [COLOR_W-1:0] floor_rgb_reg;
    logic [TEXSZ_W-1:0] tex_w_reg;
    logic [TEXSZ_W-1:0] tex_h_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ceiling_rgb_reg <= '0;
            floor_rgb_reg   <= '0;
            tex_w_reg       <= TEXSZ_RESET;
            tex_h_reg       <= TEXSZ_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CEILING_RGB: ceiling_rgb_reg <= cfg_wdata;
                CFG_FLOOR_RGB:   floor_rgb_reg   <= cfg_wdata;
                CFG_TEX_WIDTH:   tex_w_reg       <= cfg_wdata[TEXSZ_W-1:0];
                CFG_TEX_HEIGHT:  tex_h_reg       <= cfg_wdata[TEXSZ_W-1:0];
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pipeline registers
    // ---------------------------------------------------------------
    stg_a_t   a_reg,  a_next;
    stg_b_t   b_reg,  b_next;
    stg_div_t dv_reg  [DIV_STEPS+1];   // [0]: setup, [k]: quotient bit DIV_STEPS-k
    stg_div_t dv_next [DIV_STEPS+1];
    stg_e_t   e_reg,  e_next;
    stg_f_t   f_reg,  f_next;
    res_t     out_reg, skid_reg;
    logic     out_vld_reg, skid_vld_reg;

    // Whole pipeline moves while the skid slot is free; the skid slot holds
    // the one beat that can leave stage f while the output reg is blocked.
    logic en;
    assign en      = !skid_vld_reg;
    assign s_ready = en;

    logic [COLOR_W-1:0] ram_rdata;

    // ---- stage a: classify, pick face ----
    always_comb begin
        a_next.ctl.vld    = s_valid & s_ready;
        a_next.ctl.windex = s_write_index;
        a_next.ctl.wdata  = s_write_value;
        a_next.ctl.mirror = (!s_hit_side & s_dir_x_positive) | (s_hit_side & s_dir_y_sign[1]);

        if (!s_mode) begin
            a_next.ctl.region = REGION_TEXEL;
        end else if (s_row < s_slice_start) begin
            a_next.ctl.region = REGION_CEILING;
        end else if (s_row > s_slice_end) begin
            a_next.ctl.region = REGION_FLOOR;
        end else begin
            a_next.ctl.region = REGION_WALL;
        end

        if (!s_mode) begin
            a_next.ctl.face = face_t'(s_write_texture);
        end else if (!s_hit_side) begin
            a_next.ctl.face = s_dir_x_positive ? FACE_WEST : FACE_EAST;
        end else begin
            a_next.ctl.face = (s_dir_y_sign == 2'sb01) ? FACE_NORTH : FACE_SOUTH;
        end

        a_next.diff   = s_row - s_slice_start;
        a_next.frac   = s_wall_fraction;
        a_next.height = s_slice_height;
    end

    // ---- stage b: texel column and row numerator products ----
    logic [PRODX_W-1:0] prod_x;

    always_comb begin
        prod_x        = PRODX_W'(a_reg.frac) * PRODX_W'(tex_w_reg);
        b_next.ctl    = a_reg.ctl;
        b_next.tx_raw = prod_x[PRODX_W-1:FRAC_W];
        b_next.num    = NUM_W'(a_reg.diff) * NUM_W'(tex_h_reg);
        b_next.height = a_reg.height;
    end

    // ---- stage c + divider: mirror, then one quotient bit per stage ----
    logic [TEXSZ_W:0] tx_m;           // two's complement, may go to -1
    logic [CMP_W-1:0] dv_sh  [DIV_STEPS+1];
    logic [CMP_W-1:0] dv_sub [DIV_STEPS+1];

    always_comb begin
        if (b_reg.ctl.mirror) begin
            tx_m = {1'b0, tex_w_reg} - {1'b0, b_reg.tx_raw} - (TEXSZ_W+1)'(1);
        end else begin
            tx_m = {1'b0, b_reg.tx_raw};
        end

        dv_sh[0]          = CMP_W'(b_reg.height) << DIV_STEPS;
        dv_sub[0]         = '0;
        dv_next[0].ctl    = b_reg.ctl;
        dv_next[0].tx     = tx_m[TEXSZ_W-1:0];
        dv_next[0].tx_out = tx_m[TEXSZ_W] | (tx_m[TEXSZ_W-1:0] >= tex_w_reg)
                          | (32'(tx_m[TEXSZ_W-1:0]) >= 32'(TEX_MAX_WIDTH));
        dv_next[0].rem    = b_reg.num;
        dv_next[0].q      = '0;
        dv_next[0].ovf    = CMP_W'(b_reg.num) >= dv_sh[0];
        dv_next[0].height = b_reg.height;

        for (int k = 1; k <= DIV_STEPS; k++) begin
            dv_next[k]  = dv_reg[k-1];
            dv_sh[k]    = CMP_W'(dv_reg[k-1].height) << (DIV_STEPS - k);
            dv_sub[k]   = CMP_W'(dv_reg[k-1].rem) - dv_sh[k];
            if (CMP_W'(dv_reg[k-1].rem) >= dv_sh[k]) begin
                dv_next[k].rem             = dv_sub[k][NUM_W-1:0];
                dv_next[k].q[DIV_STEPS-k]  = 1'b1;
            end
        end
    end

    // ---- stage e: bounds check, texture store access ----
    always_comb begin
        e_next.ctl     = dv_reg[DIV_STEPS].ctl;
        e_next.tx      = dv_reg[DIV_STEPS].tx;
        e_next.q       = dv_reg[DIV_STEPS].q;
        e_next.outside = dv_reg[DIV_STEPS].tx_out | dv_reg[DIV_STEPS].ovf
                       | (dv_reg[DIV_STEPS].q >= tex_h_reg)
                       | (32'(dv_reg[DIV_STEPS].q) >= 32'(TEX_MAX_HEIGHT));
    end

    // Reads and writes both happen from stage e, so store accesses keep item
    // order and a read issued the cycle after a write sees the new texel.
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;

    assign ram_we    = en & e_reg.ctl.vld & (e_reg.ctl.region == REGION_TEXEL)
                     & (32'(e_reg.ctl.windex) < 32'(TEX_AREA));
    assign ram_re    = en & e_reg.ctl.vld & (e_reg.ctl.region == REGION_WALL)
                     & !e_reg.outside;
    assign ram_waddr = ADDR_W'(e_reg.ctl.face) * ADDR_W'(TEX_AREA) + ADDR_W'(e_reg.ctl.windex);
    assign ram_raddr = ADDR_W'(e_reg.ctl.face) * ADDR_W'(TEX_AREA)
                     + ADDR_W'(e_reg.q) * ADDR_W'(TEX_MAX_WIDTH) + ADDR_W'(e_reg.tx);

    rwct_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (STORE_DEPTH)
    ) u_tex_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (e_reg.ctl.wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // ---- stage f: read data lines up with this stage ----
    always_comb begin
        f_next.vld     = e_reg.ctl.vld;
        f_next.region  = e_reg.ctl.region;
        f_next.outside = e_reg.outside;
    end

    res_t f_res;

    always_comb begin
        f_res.region  = f_reg.region;
        f_res.outside = 1'b0;
        unique case (f_reg.region)
            REGION_CEILING: f_res.color = ceiling_rgb_reg;
            REGION_FLOOR:   f_res.color = floor_rgb_reg;
            REGION_WALL: begin
                f_res.color   = f_reg.outside ? '0 : ram_rdata;
                f_res.outside = f_reg.outside;
            end
            REGION_TEXEL:   f_res.color = '0;
        endcase
    end

    // ---- sequential: pipeline advance, output reg and skid slot ----
    logic out_free;
    assign out_free = !out_vld_reg | m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg.ctl.vld <= 1'b0;
            b_reg.ctl.vld <= 1'b0;
            for (int k = 0; k <= DIV_STEPS; k++) begin
                dv_reg[k].ctl.vld <= 1'b0;
            end
            e_reg.ctl.vld <= 1'b0;
            f_reg.vld     <= 1'b0;
            out_vld_reg   <= 1'b0;
            skid_vld_reg  <= 1'b0;
        end else begin
            if (en) begin
                a_reg <= a_next;
                b_reg <= b_next;
                for (int k = 0; k <= DIV_STEPS; k++) begin
                    dv_reg[k] <= dv_next[k];
                end
                e_reg <= e_next;
                f_reg <= f_next;
            end

            if (skid_vld_reg) begin
                // pipeline frozen; drain skid into output when possible
                if (out_free) begin
                    out_reg      <= skid_reg;
                    out_vld_reg  <= 1'b1;
                    skid_vld_reg <= 1'b0;
                end
            end else if (f_reg.vld) begin
                if (out_free) begin
                    out_reg     <= f_res;
                    out_vld_reg <= 1'b1;
                end else begin
                    skid_reg     <= f_res;
                    skid_vld_reg <= 1'b1;
                end
            end else if (out_free) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign m_valid         = out_vld_reg;
    assign m_pixel_color   = out_reg.color;
    assign m_region        = out_reg.region;
    assign m_texel_outside = out_reg.outside;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> m_valid)
        else $error("skid slot full while output reg empty");

    a_texel_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_region == REGION_TEXEL) |-> (m_pixel_color == '0 && !m_texel_outside))
        else $error("texel write beat carries color or outside flag");

    a_outside_black: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_texel_outside) |-> (m_region == REGION_WALL && m_pixel_color == '0))
        else $error("outside texel not black or not on wall");

    a_no_store_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_re |=> !(ram_we && ram_waddr == $past(ram_raddr) && !en))
        else $error("texture store written under a pending read");

endmodule
